FILE: rtl/core/bcba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap contiguous block allocator package
// Shared widths, codes, controller states and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcba_pkg;

	localparam int DEFAULT_MAX_BLOCKS = 1024;

	localparam int WORD_W  = 32;
	localparam int WORD_LW = 5;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 10;
	localparam int CNT_W     = 11;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 1;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;
	localparam int M_PAD_W   = M_TDATA_W - ST_W - IDX_W;

	localparam int VOLUME_RESET   = 1024;
	localparam int RESERVED_RESET = 0;

	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_FIND  = 2'd1,
		OP_ALLOC = 2'd2,
		OP_FREE  = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK           = 2'd0,
		ST_NOT_FOUND    = 2'd1,
		ST_OUT_OF_RANGE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VOLUME   = 1'b0,
		CFG_RESERVED = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SRC_INIT  = 2'd0,
		SRC_FREE  = 2'd1,
		SRC_ALLOC = 2'd2
	} rmw_src_t;

	typedef enum logic [2:0] {
		S_IDLE      = 3'd0,
		S_CHECK     = 3'd1,
		S_SCAN      = 3'd2,
		S_RMW_START = 3'd3,
		S_RMW       = 3'd4,
		S_RMW_WAIT  = 3'd5,
		S_DONE      = 3'd6
	} state_t;

	typedef struct packed {
		logic     load;
		logic     clear_valid;
		logic     set_status;
		status_t  status;
		logic     scan_init;
		logic     scan_rd;
		logic     take_hit;
		logic     rmw_load;
		rmw_src_t rmw_src;
		logic     rmw_rd;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic req_bad;
		logic free_bad;
		logic cnt_zero;
		logic init_empty;
		logic scan_hit;
		logic scan_miss;
		logic rmw_last;
		logic out_busy;
	} sts_t;

endpackage

FILE: rtl/core/bitmap_contiguous_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Bitmap contiguous block allocator, top level
// A find scans the 32-block map rows in order (at most 32 rows for 1024 blocks),
// reading one map row per cycle. Allocate then marks the rows that the run
// touches; free and init mark their rows straight after the check, and a
// request with nothing to scan or mark goes straight to the result.
// One request at a time; a new one is taken while the last result waits.
// Reset clears the map to all free and loads the register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_contiguous_block_allocator_top #(
	parameter int MAX_BLOCKS = bcba_pkg::DEFAULT_MAX_BLOCKS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// opcode, start_block, block_count
	input  logic [bcba_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status, start_index
	output logic [bcba_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            cfg_we,
	input  logic [bcba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bcba_pkg::CNT_W-1:0]      cfg_wdata
);
	import bcba_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [ST_W-1:0]  out_status;
	logic [IDX_W-1:0] out_start_index;

	bcba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bcba_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_opcode       (s_tdata[OP_W-1:0]),
		.in_start_block  (s_tdata[OP_W+IDX_W-1:OP_W]),
		.in_block_count  (s_tdata[OP_W+IDX_W+CNT_W-1:OP_W+IDX_W]),
		.cmd             (cmd),
		.sts             (sts),
		.m_tready        (m_tready),
		.m_tvalid        (m_tvalid),
		.out_status      (out_status),
		.out_start_index (out_start_index)
	);

	assign m_tdata = {{M_PAD_W{1'b0}}, out_start_index, out_status};

endmodule

FILE: rtl/core/bcba_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences one request at a time through check, bitmap scan and the
// read-modify-write pass over the map rows, then hands the result on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  bcba_pkg::sts_t  sts,
	output bcba_pkg::cmd_t  cmd
);
	import bcba_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				case (sts.op)
					OP_INIT: begin
						state_d = sts.init_empty ? S_DONE : S_RMW;
					end
					OP_FIND, OP_ALLOC: begin
						state_d = sts.req_bad ? S_DONE : S_SCAN;
					end
					OP_FREE: begin
						state_d = (sts.free_bad || sts.cnt_zero) ? S_DONE : S_RMW;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.scan_hit) begin
					state_d = (sts.op == OP_ALLOC) ? S_RMW_START : S_DONE;
				end else if (sts.scan_miss) begin
					state_d = S_DONE;
				end
			end
			S_RMW_START: begin
				state_d = S_RMW;
			end
			S_RMW: begin
				if (sts.rmw_last) begin
					state_d = S_RMW_WAIT;
				end
			end
			S_RMW_WAIT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_CHECK: begin
				cmd.set_status = 1'b1;
				cmd.status     = ST_OK;
				case (sts.op)
					OP_INIT: begin
						cmd.clear_valid = 1'b1;
						cmd.rmw_load    = 1'b1;
						cmd.rmw_src     = SRC_INIT;
					end
					OP_FIND, OP_ALLOC: begin
						if (sts.req_bad) begin
							cmd.status = ST_NOT_FOUND;
						end else begin
							cmd.scan_init = 1'b1;
						end
					end
					OP_FREE: begin
						if (sts.free_bad) begin
							cmd.status = ST_OUT_OF_RANGE;
						end else begin
							cmd.rmw_load = 1'b1;
							cmd.rmw_src  = SRC_FREE;
						end
					end
					default: begin
						cmd.status = ST_OK;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_hit) begin
					cmd.take_hit = 1'b1;
				end else if (sts.scan_miss) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOT_FOUND;
				end
			end
			S_RMW_START: begin
				cmd.rmw_load = 1'b1;
				cmd.rmw_src  = SRC_ALLOC;
			end
			S_RMW: begin
				cmd.rmw_rd = 1'b1;
			end
			S_RMW_WAIT: begin
				cmd.rmw_rd = 1'b0;
			end
			S_DONE: begin
				cmd.out_load = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/core/bcba_dp.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Holds the configuration, the request, the used-block map in 32-bit rows,
// the two-stage first-fit scan pipeline, the row read-modify-write path and
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcba_dp #(
	parameter int MAX_BLOCKS = bcba_pkg::DEFAULT_MAX_BLOCKS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bcba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bcba_pkg::CNT_W-1:0]      cfg_wdata,
	input  logic [bcba_pkg::OP_W-1:0]       in_opcode,
	input  logic [bcba_pkg::IDX_W-1:0]      in_start_block,
	input  logic [bcba_pkg::CNT_W-1:0]      in_block_count,
	input  bcba_pkg::cmd_t                  cmd,
	output bcba_pkg::sts_t                  sts,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [bcba_pkg::ST_W-1:0]       out_status,
	output logic [bcba_pkg::IDX_W-1:0]      out_start_index
);
	import bcba_pkg::*;

	localparam int ROWS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IW   = ($clog2(MAX_BLOCKS) + 1 > 12) ? $clog2(MAX_BLOCKS) + 1 : 12;

	localparam logic [WORD_W-1:0]  ONES     = {WORD_W{1'b1}};
	localparam logic [WORD_LW-1:0] TOP_BIT  = WORD_LW'(WORD_W - 1);

	// Configuration registers.
	logic [CNT_W-1:0] volume_q;
	logic [CNT_W-1:0] reserved_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q   <= CNT_W'(VOLUME_RESET);
			reserved_q <= CNT_W'(RESERVED_RESET);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VOLUME:   volume_q   <= cfg_wdata;
				CFG_RESERVED: reserved_q <= cfg_wdata;
				default: begin
					volume_q <= volume_q;
				end
			endcase
		end
	end

	logic [IW-1:0] vol;
	logic [IW-1:0] rclip;

	assign vol   = (IW'(volume_q) > IW'(MAX_BLOCKS)) ? IW'(MAX_BLOCKS) : IW'(volume_q);
	assign rclip = (IW'(reserved_q) > vol) ? vol : IW'(reserved_q);

	// Request registers.
	op_t           op_q;
	logic [IW-1:0] sb_q;
	logic [IW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(in_opcode);
			sb_q  <= IW'(in_start_block);
			cnt_q <= IW'(in_block_count);
		end
	end

	logic [IW-1:0] free_end;
	assign free_end = sb_q + cnt_q;

	// Map storage: one row of WORD_W blocks per entry, a row that was never
	// written since the last init reads as all free.
	logic [WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0]   row_valid_q;

	logic              scan_issue;
	logic              rmw_issue;
	logic              rd_en;
	logic [RW-1:0]     rd_row;
	logic [RW-1:0]     scan_row_q;
	logic              scan_all_q;
	logic [RW-1:0]     scan_last_row;
	logic [RW-1:0]     rmw_row_q;

	logic [WORD_W-1:0] rdata_s1;
	logic              rvalid_s1;
	logic [RW-1:0]     row_s1;
	logic              last_s1;
	logic              scan_s1;
	logic              rmw_s1;
	logic [WORD_W-1:0] word_s1;

	logic              wr_en;
	logic [WORD_W-1:0] wdata;

	assign scan_last_row = RW'((vol - IW'(1)) >> WORD_LW);
	assign scan_issue    = cmd.scan_rd && !scan_all_q;
	assign rmw_issue     = cmd.rmw_rd;
	assign rd_en         = scan_issue || rmw_issue;
	assign rd_row        = rmw_issue ? rmw_row_q : scan_row_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1  <= mem[rd_row];
			rvalid_s1 <= row_valid_q[rd_row];
			row_s1    <= rd_row;
			last_s1   <= (scan_row_q == scan_last_row);
		end
		if (wr_en) begin
			mem[row_s1] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.clear_valid) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[row_s1] <= 1'b1;
		end
	end

	assign word_s1 = rvalid_s1 ? rdata_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
			rmw_s1  <= 1'b0;
		end else begin
			scan_s1 <= scan_issue && !cmd.scan_init;
			rmw_s1  <= rmw_issue;
		end
	end

	// Scan row counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			scan_all_q <= 1'b0;
		end else if (cmd.scan_init) begin
			scan_row_q <= '0;
			scan_all_q <= 1'b0;
		end else if (scan_issue) begin
			if (scan_row_q == scan_last_row) begin
				scan_all_q <= 1'b1;
			end else begin
				scan_row_q <= scan_row_q + RW'(1);
			end
		end
	end

	// Scan stage one: run length of free blocks ending at each bit of the row.
	logic [WORD_W-1:0]  used_a;
	logic [WORD_W-1:0]  beyond_a;
	logic [WORD_LW-1:0] vlast_bit;
	logic [WORD_W-1:0]  has_l [WORD_LW+1];
	logic [WORD_LW-1:0] idx_l [WORD_LW+1][WORD_W];
	logic [IW-1:0]      run_a [WORD_W];
	logic [IW-1:0]      run_next;
	logic [IW-1:0]      run_q;

	assign vlast_bit = WORD_LW'(vol - IW'(1));
	assign beyond_a  = (row_s1 == scan_last_row) ? ~(ONES >> (TOP_BIT - vlast_bit)) : '0;
	assign used_a    = word_s1 | beyond_a;

	always_comb begin
		for (int p = 0; p < WORD_W; p++) begin
			has_l[0][p] = used_a[p];
			idx_l[0][p] = WORD_LW'(p);
		end
		for (int l = 0; l < WORD_LW; l++) begin
			for (int p = 0; p < WORD_W; p++) begin
				if (p >= (1 << l) && !has_l[l][p]) begin
					has_l[l+1][p] = has_l[l][p - (1 << l)];
					idx_l[l+1][p] = idx_l[l][p - (1 << l)];
				end else begin
					has_l[l+1][p] = has_l[l][p];
					idx_l[l+1][p] = idx_l[l][p];
				end
			end
		end
		for (int p = 0; p < WORD_W; p++) begin
			if (used_a[p]) begin
				run_a[p] = '0;
			end else if (has_l[WORD_LW][p]) begin
				run_a[p] = IW'(p) - IW'(idx_l[WORD_LW][p]);
			end else begin
				run_a[p] = run_q + IW'(p + 1);
			end
		end
		if (has_l[WORD_LW][WORD_W-1]) begin
			run_next = IW'(WORD_W - 1) - IW'(idx_l[WORD_LW][WORD_W-1]);
		end else begin
			run_next = run_q + IW'(WORD_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (cmd.scan_init) begin
			run_q <= '0;
		end else if (scan_s1) begin
			run_q <= run_next;
		end
	end

	logic [IW-1:0] run_s2 [WORD_W];
	logic [RW-1:0] row_s2;
	logic          last_s2;
	logic          scan_s2;

	always_ff @(posedge clk) begin
		if (scan_s1) begin
			for (int p = 0; p < WORD_W; p++) begin
				run_s2[p] <= run_a[p];
			end
			row_s2  <= row_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s2 <= 1'b0;
		end else begin
			scan_s2 <= scan_s1 && !cmd.scan_init;
		end
	end

	// Scan stage two: first bit whose run reaches the requested length.
	logic [WORD_W-1:0]  ok_b;
	logic [WORD_LW-1:0] hit_pos;
	logic [IW-1:0]      hit_start;

	always_comb begin
		hit_pos = '0;
		for (int p = 0; p < WORD_W; p++) begin
			ok_b[p] = (run_s2[p] >= cnt_q);
		end
		for (int p = WORD_W - 1; p >= 0; p--) begin
			if (ok_b[p]) begin
				hit_pos = WORD_LW'(p);
			end
		end
	end

	assign hit_start = (IW'(row_s2) << WORD_LW) + IW'(hit_pos) + IW'(1) - cnt_q;

	// Result and found-run registers.
	status_t        res_status_q;
	logic [IDX_W-1:0] res_start_q;
	logic [IW-1:0]  found_q;

	always_ff @(posedge clk) begin
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
			res_start_q  <= '0;
		end else if (cmd.take_hit) begin
			res_start_q <= hit_start[IDX_W-1:0];
		end
		if (cmd.take_hit) begin
			found_q <= hit_start;
		end
	end

	// Row read-modify-write over a block range.
	logic [IW-1:0] rng_lo;
	logic [IW-1:0] rng_end;
	logic          rng_set;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] last_q;
	logic          set_q;
	logic [RW-1:0] first_row;
	logic [RW-1:0] last_row;

	always_comb begin
		case (cmd.rmw_src)
			SRC_INIT: begin
				rng_lo  = '0;
				rng_end = rclip;
				rng_set = 1'b1;
			end
			SRC_FREE: begin
				rng_lo  = sb_q;
				rng_end = free_end;
				rng_set = 1'b0;
			end
			SRC_ALLOC: begin
				rng_lo  = found_q;
				rng_end = found_q + cnt_q;
				rng_set = 1'b1;
			end
			default: begin
				rng_lo  = '0;
				rng_end = '0;
				rng_set = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rmw_load) begin
			lo_q   <= rng_lo;
			last_q <= rng_end - IW'(1);
			set_q  <= rng_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmw_row_q <= '0;
		end else if (cmd.rmw_load) begin
			rmw_row_q <= RW'(rng_lo >> WORD_LW);
		end else if (rmw_issue) begin
			rmw_row_q <= rmw_row_q + RW'(1);
		end
	end

	assign first_row = RW'(lo_q >> WORD_LW);
	assign last_row  = RW'(last_q >> WORD_LW);

	logic [WORD_LW-1:0] lo_b;
	logic [WORD_LW-1:0] hi_b;
	logic [WORD_W-1:0]  rmw_mask;

	assign lo_b     = (row_s1 == first_row) ? lo_q[WORD_LW-1:0] : '0;
	assign hi_b     = (row_s1 == last_row) ? last_q[WORD_LW-1:0] : TOP_BIT;
	assign rmw_mask = (ONES << lo_b) & (ONES >> (TOP_BIT - hi_b));
	assign wr_en    = rmw_s1;
	assign wdata    = set_q ? (word_s1 | rmw_mask) : (word_s1 & ~rmw_mask);

	// Output register.
	logic             out_valid_q;
	status_t          out_status_q;
	logic [IDX_W-1:0] out_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_start_q  <= res_start_q;
		end
	end

	assign m_tvalid        = out_valid_q;
	assign out_status      = out_status_q;
	assign out_start_index = out_start_q;

	// Status toward the controller.
	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.req_bad    = (cnt_q == '0) || (cnt_q > vol);
		sts.free_bad   = (sb_q >= vol) || (free_end > vol);
		sts.cnt_zero   = (cnt_q == '0);
		sts.init_empty = (rclip == '0);
		sts.scan_hit   = scan_s2 && (|ok_b);
		sts.scan_miss  = scan_s2 && last_s2 && !(|ok_b);
		sts.rmw_last   = (rmw_row_q == last_row);
		sts.out_busy   = out_valid_q && !m_tready;
	end

endmodule

FILE: test/tb_bitmap_contiguous_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Testbench for the bitmap contiguous block allocator
// Runs a short table of directed requests, then random init, find, allocate
// and free requests under several volume and reserved settings. It keeps its
// own copy of the used-block map and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_contiguous_block_allocator_top;

	import bcba_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int MAP_BLOCKS  = DEFAULT_MAX_BLOCKS;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 120;
	localparam int PHASES      = 8;

	typedef struct packed {
		status_t     st;
		logic [9:0]  at;
	} answer_t;

	typedef struct {
		op_t     op;
		int      first;
		int      len;
		bit      typed;
		status_t st;
		int      at;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// opcode, start_block, block_count
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	// status, start_index
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we;
	cfg_idx_t             cfg_index;
	logic [CNT_W-1:0]     cfg_wdata;

	bit          block_used [0:MAP_BLOCKS-1];
	int          volume_reg = VOLUME_RESET;
	int          reserved_reg = RESERVED_RESET;
	answer_t     answers_due [$];
	int          run_lo [$];
	int          run_len [$];

	bit          send_gaps;
	bit          sink_gaps;
	bit          hold_req;
	int          errors;
	int          results_seen;
	int          op_tally [4];
	int          granted;
	int          not_found;
	int          out_of_range;
	int          settings_used;

	step_row_t directed [25] = '{
		'{OP_FIND,     0,    1, 1'b1, ST_OK,           0},
		'{OP_FIND,     0, 1024, 1'b1, ST_OK,           0},
		'{OP_FIND,     0, 1025, 1'b1, ST_NOT_FOUND,    0},
		'{OP_FIND,     0,    0, 1'b1, ST_NOT_FOUND,    0},
		'{OP_ALLOC,    0,    0, 1'b1, ST_NOT_FOUND,    0},
		'{OP_ALLOC,    0, 1024, 1'b1, ST_OK,           0},
		'{OP_FIND,     0,    1, 1'b1, ST_NOT_FOUND,    0},
		'{OP_FREE,  1023,    1, 1'b1, ST_OK,           0},
		'{OP_FIND,     0,    1, 1'b1, ST_OK,        1023},
		'{OP_FREE,  1023,    2, 1'b1, ST_OUT_OF_RANGE, 0},
		'{OP_FREE,  1023,    0, 1'b1, ST_OK,           0},
		'{OP_FREE,     0, 2047, 1'b1, ST_OUT_OF_RANGE, 0},
		'{OP_FREE,     0, 1024, 1'b1, ST_OK,           0},
		'{OP_ALLOC,    0,    3, 1'b1, ST_OK,           0},
		'{OP_ALLOC,    0,    5, 1'b1, ST_OK,           3},
		'{OP_FREE,     1,    1, 1'b1, ST_OK,           0},
		'{OP_ALLOC,    0,    2, 1'b0, ST_OK,           0},
		'{OP_ALLOC,    0,    1, 1'b0, ST_OK,           0},
		'{OP_FIND,     0, 2047, 1'b1, ST_NOT_FOUND,    0},
		'{OP_INIT,  1023, 2047, 1'b1, ST_OK,           0},
		'{OP_FIND,     0, 1024, 1'b1, ST_OK,           0},
		'{OP_ALLOC, 1000,  512, 1'b0, ST_OK,           0},
		'{OP_ALLOC,    0,  512, 1'b0, ST_OK,           0},
		'{OP_FREE,   512,  512, 1'b0, ST_OK,           0},
		'{OP_ALLOC,    0,   24, 1'b0, ST_OK,           0}
	};

	int phase_volume   [PHASES] = '{1024, 1, 0, 2047, 1024, 37, 300, 777};
	int phase_reserved [PHASES] = '{0, 0, 5, 2047, 1024, 3, 1030, 20};
	int phase_items    [PHASES] = '{220, 80, 60, 220, 150, 200, 220, 280};

	bitmap_contiguous_block_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int live_volume();
		return (volume_reg > MAP_BLOCKS) ? MAP_BLOCKS : volume_reg;
	endfunction

	// Applies one request to the local map and returns the answer it should give.
	function automatic answer_t apply_to_map(input op_t op, input int first, input int len);
		answer_t ans;
		int      vol;
		int      lim;
		int      run;
		int      b;
		int      hit_at;
		bit      hit;
		vol = live_volume();
		ans.st = ST_OK;
		ans.at = '0;
		case (op)
			OP_INIT: begin
				lim = (reserved_reg > vol) ? vol : reserved_reg;
				for (b = 0; b < MAP_BLOCKS; b++)
					block_used[b] = (b < lim);
			end
			OP_FIND, OP_ALLOC: begin
				hit = 1'b0;
				hit_at = 0;
				run = 0;
				if (len != 0 && len <= vol) begin
					for (b = 0; b < vol && !hit; b++) begin
						if (block_used[b]) begin
							run = 0;
						end else begin
							run++;
							if (run == len) begin
								hit = 1'b1;
								hit_at = b + 1 - len;
							end
						end
					end
				end
				if (!hit) begin
					ans.st = ST_NOT_FOUND;
				end else begin
					ans.at = hit_at[9:0];
					if (op == OP_ALLOC) begin
						for (b = hit_at; b < hit_at + len; b++)
							block_used[b] = 1'b1;
					end
				end
			end
			default: begin
				if (first >= vol || first + len > vol) begin
					ans.st = ST_OUT_OF_RANGE;
				end else begin
					for (b = first; b < first + len; b++)
						block_used[b] = 1'b0;
				end
			end
		endcase
		return ans;
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return $urandom_range(3, 1);
		if (r < 95)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic int pick_len(input int vol);
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 0;
		if (r < 70)
			return $urandom_range(8, 1);
		if (r < 88)
			return $urandom_range(64, 1);
		if (r < 96)
			return $urandom_range((vol > 1) ? vol : 1, 1);
		return $urandom_range(2047, 0);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic check_answer();
		answer_t want;
		if (answers_due.size() == 0) begin
			report_mismatch("result with no request outstanding, tdata", m_tdata, 0);
			return;
		end
		want = answers_due.pop_front();
		results_seen++;
		if (m_tdata[ST_W-1:0] !== want.st)
			report_mismatch("status", m_tdata[ST_W-1:0], want.st);
		if (m_tdata[ST_W+IDX_W-1:ST_W] !== want.at)
			report_mismatch("start_index", m_tdata[ST_W+IDX_W-1:ST_W], want.at);
	endtask

	// Offers one request, waits for it to be taken and records its answer.
	task automatic issue(input op_t op, input int first, input int len, input bit typed,
			input status_t st_k, input int at_k);
		answer_t ans;
		int      gap;
		s_tdata <= {1'b0, len[CNT_W-1:0], first[IDX_W-1:0], op};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		ans = apply_to_map(op, first, len);
		if (typed) begin
			ans.st = st_k;
			ans.at = at_k[9:0];
		end
		answers_due.push_back(ans);
		op_tally[op]++;
		if (op == OP_INIT) begin
			run_lo.delete();
			run_len.delete();
		end
		if (ans.st == ST_OK && op == OP_ALLOC) begin
			run_lo.push_back(ans.at);
			run_len.push_back(len);
			granted++;
		end
		if (ans.st == ST_NOT_FOUND)
			not_found++;
		if (ans.st == ST_OUT_OF_RANGE)
			out_of_range++;
		gap = 0;
		if (send_gaps && $urandom_range(99) >= 60)
			gap = pause_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_request();
		op_t op;
		int  first;
		int  len;
		int  vol;
		int  r;
		int  k;
		vol = live_volume();
		r = $urandom_range(99);
		op = (r < 4) ? OP_INIT : (r < 30) ? OP_FIND : (r < 62) ? OP_ALLOC : OP_FREE;
		first = $urandom_range(1023, 0);
		len = pick_len(vol);
		if (op == OP_FREE) begin
			r = $urandom_range(99);
			if (run_lo.size() > 0 && r < 65) begin
				k = $urandom_range(run_lo.size() - 1, 0);
				first = run_lo[k];
				len = run_len[k];
				run_lo.delete(k);
				run_len.delete(k);
			end else if (r < 88 && vol > 0) begin
				first = $urandom_range(vol - 1, 0);
				len = $urandom_range((vol - first < 16) ? vol - first : 16, 0);
			end
		end
		issue(op, first, len, 1'b0, ST_OK, 0);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input int vol, input int rsv);
		cfg_we <= 1'b1;
		cfg_index <= CFG_VOLUME;
		cfg_wdata <= vol[CNT_W-1:0];
		@(posedge clk);
		volume_reg = vol;
		cfg_index <= CFG_RESERVED;
		cfg_wdata <= rsv[CNT_W-1:0];
		@(posedge clk);
		reserved_reg = rsv;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin : sink
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready)
				check_answer();
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (stall == 0 && sink_gaps && $urandom_range(99) < 25) begin
				stall = pause_len();
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int i;
		int p;
		for (i = 0; i < MAP_BLOCKS; i++)
			block_used[i] = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_VOLUME;
		cfg_wdata <= '0;
		send_gaps = 1'b0;
		sink_gaps = 1'b0;
		hold_req = 1'b0;
		settings_used = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			issue(directed[i].op, directed[i].first, directed[i].len, directed[i].typed,
				directed[i].st, directed[i].at);

		for (p = 0; p < PHASES; p++) begin
			send_gaps = (p != 5);
			sink_gaps = (p != 5);
			if (p != 0) begin
				drain();
				configure(phase_volume[p], phase_reserved[p]);
			end
			issue(OP_INIT, 0, 0, 1'b0, ST_OK, 0);
			for (i = 1; i < phase_items[p]; i++) begin
				if (p == 0 && i == 60)
					hold_req = 1'b1;
				random_request();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d init, %0d find, %0d allocate and %0d free requests under %0d settings.",
			op_tally[OP_INIT], op_tally[OP_FIND], op_tally[OP_ALLOC], op_tally[OP_FREE],
			settings_used);
		$display("%0d runs allocated, %0d not found, %0d out of range; %0d results, %0d errors.",
			granted, not_found, out_of_range, results_seen, errors);
		if (errors == 0 && answers_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/bcba_pkg.sv
rtl/core/bcba_ctrl.sv
rtl/core/bcba_dp.sv
rtl/core/bitmap_contiguous_block_allocator_top.sv
test/tb_bitmap_contiguous_block_allocator_top.sv
